// ===== hdl/hdfr_pkg.sv =====
// Types, codes and helpers shared by the DLE/ETX HDLC frame receiver.
`timescale 1ns / 1ps

package hdfr_pkg;

    localparam logic [7:0] CH_DLE    = 8'h10;
    localparam logic [7:0] CH_ETX    = 8'h03;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] ADDR_BYTE = 8'hff;
    localparam logic [7:0] CTRL_MASK = 8'hf7;
    localparam logic [7:0] CTRL_WANT = 8'hc0;
    localparam logic [3:0] MIN_BASE  = 4'd3;
    localparam logic [3:0] COUNT_MAX = 4'd15;

    localparam logic CFG_REVERSE = 1'b0;
    localparam logic CFG_TRAILER = 1'b1;

    localparam logic REQ_BYTE    = 1'b0;
    localparam logic REQ_TIMEOUT = 1'b1;

    typedef enum logic [1:0] {
        PH_HUNT  = 2'd0,
        PH_FRAME = 2'd1,
        PH_ESC   = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        ST_GOOD    = 3'd0,
        ST_TIMEOUT = 3'd1,
        ST_NOADDR  = 3'd2,
        ST_SHORT   = 3'd3,
        ST_BADCTL  = 3'd4
    } t_status;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic       is_status;
        logic [7:0] out_byte;
        t_status    status;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_result;

    function automatic logic [7:0] flip8(input logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = b[7 - i];
        end
        return r;
    endfunction

endpackage

// ===== hdl/hdfr_unstuff.sv =====
// Frame state, DLE unstuffing and status decision for one accepted transfer.
`timescale 1ns / 1ps

module hdfr_unstuff (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [2:0]         i_cfg_data,
    input  logic               i_accept,
    input  hdfr_pkg::t_in_item i_item,
    output hdfr_pkg::t_result  o_result
);

    logic             r_reverse;
    logic [2:0]       r_trailer;
    hdfr_pkg::t_phase r_phase, n_phase;
    logic             r_prev_cr, n_prev_cr;
    logic [3:0]       r_count, n_count;
    logic             r_ctl_good, n_ctl_good;

    logic [7:0] b;
    logic [7:0] v;
    logic       emit_byte;
    logic [3:0] base_count;
    logic [3:0] min_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reverse <= 1'b0;
            r_trailer <= 3'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                hdfr_pkg::CFG_REVERSE: r_reverse <= i_cfg_data[0];
                hdfr_pkg::CFG_TRAILER: r_trailer <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= hdfr_pkg::PH_HUNT;
            r_prev_cr  <= 1'b0;
            r_count    <= 4'd0;
            r_ctl_good <= 1'b0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_prev_cr  <= n_prev_cr;
            r_count    <= n_count;
            r_ctl_good <= n_ctl_good;
        end
    end

    assign b       = i_item.rx_byte;
    assign v       = r_reverse ? hdfr_pkg::flip8(b) : b;
    assign min_len = hdfr_pkg::MIN_BASE + {1'b0, r_trailer};

    always_comb begin
        n_phase    = r_phase;
        n_prev_cr  = r_prev_cr;
        n_count    = r_count;
        n_ctl_good = r_ctl_good;
        emit_byte  = 1'b0;
        base_count = r_count;
        o_result   = '0;

        if (i_item.req_type == hdfr_pkg::REQ_TIMEOUT) begin
            o_result.valid       = 1'b1;
            o_result.item.status = hdfr_pkg::ST_TIMEOUT;
        end else begin
            case (r_phase)
                hdfr_pkg::PH_FRAME: begin
                    if (b == hdfr_pkg::CH_DLE) begin
                        n_phase = hdfr_pkg::PH_ESC;
                    end else begin
                        emit_byte = 1'b1;
                    end
                end
                hdfr_pkg::PH_ESC: begin
                    if (b == hdfr_pkg::CH_ETX) begin
                        o_result.valid = 1'b1;
                        if (r_count < min_len) begin
                            o_result.item.status = hdfr_pkg::ST_SHORT;
                        end else if (!r_ctl_good) begin
                            o_result.item.status = hdfr_pkg::ST_BADCTL;
                        end else begin
                            o_result.item.status = hdfr_pkg::ST_GOOD;
                        end
                    end else begin
                        n_phase   = hdfr_pkg::PH_FRAME;
                        emit_byte = 1'b1;
                    end
                end
                default: begin
                    if (b == hdfr_pkg::ADDR_BYTE) begin
                        n_phase    = hdfr_pkg::PH_FRAME;
                        n_prev_cr  = 1'b0;
                        n_ctl_good = 1'b0;
                        base_count = 4'd0;
                        emit_byte  = 1'b1;
                    end else if (b == hdfr_pkg::CH_LF && r_prev_cr) begin
                        o_result.valid       = 1'b1;
                        o_result.item.status = hdfr_pkg::ST_NOADDR;
                    end else begin
                        n_phase   = hdfr_pkg::PH_HUNT;
                        n_prev_cr = (b == hdfr_pkg::CH_CR);
                    end
                end
            endcase
        end

        if (emit_byte) begin
            if (base_count == 4'd1) begin
                n_ctl_good = ((v & hdfr_pkg::CTRL_MASK) == hdfr_pkg::CTRL_WANT);
            end
            n_count = (base_count == hdfr_pkg::COUNT_MAX) ? base_count : base_count + 4'd1;
            o_result.valid         = 1'b1;
            o_result.item.out_byte = v;
        end

        // any status ends the attempt
        if (o_result.valid && !emit_byte) begin
            o_result.item.is_status = 1'b1;
            o_result.item.last      = 1'b1;
            n_phase    = hdfr_pkg::PH_HUNT;
            n_prev_cr  = 1'b0;
            n_count    = 4'd0;
            n_ctl_good = 1'b0;
        end
    end

endmodule

// ===== hdl/hdfr_out_buf.sv =====
// Result register with a skid stage, so input stall depends on registers only.
`timescale 1ns / 1ps

module hdfr_out_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  hdfr_pkg::t_out_item i_item,
    output logic                o_full,
    output logic                o_valid,
    output hdfr_pkg::t_out_item o_item,
    input  logic                i_stall
);

    logic                r_out_valid;
    logic                r_skid_valid;
    hdfr_pkg::t_out_item r_out;
    hdfr_pkg::t_out_item r_skid;
    logic                take;

    assign take    = r_out_valid && !i_stall;
    assign o_valid = r_out_valid;
    assign o_item  = r_out;
    assign o_full  = r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (!r_out_valid || take) begin
                r_out <= i_item;
            end else begin
                r_skid <= i_item;
            end
        end
    end

endmodule

// ===== hdl/hdlc_dle_frame_receiver.sv =====
// Top level of the DLE/ETX HDLC frame receiver: unstuffing core and result buffer.
// Each result is registered in the result buffer before it is presented on o_out_valid.
// Throughput: one input transfer per cycle while o_in_stall is low; the frame state updates on each accepted transfer.
// The two-entry result buffer holds one result behind a stalled one; input stalls only when both are full.
// Reset (synchronous, active low) returns to hunting and clears both config registers.
`timescale 1ns / 1ps

module hdlc_dle_frame_receiver (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [2:0]          i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  hdfr_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output hdfr_pkg::t_out_item o_out_data
);

    logic              in_accept;
    logic              buf_full;
    hdfr_pkg::t_result result;

    assign o_in_stall = buf_full;
    assign in_accept  = i_in_valid && !buf_full;

    hdfr_unstuff u_unstuff (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (in_accept),
        .i_item     (i_in_data),
        .o_result   (result)
    );

    hdfr_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept && result.valid),
        .i_item  (result.item),
        .o_full  (buf_full),
        .o_valid (o_out_valid),
        .o_item  (o_out_data),
        .i_stall (i_out_stall)
    );

    a_stall_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty result register");

    a_status_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.is_status) |->
            (o_out_data.last && o_out_data.out_byte == 8'h00))
        else $error("status transfer malformed");

    a_byte_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.is_status) |->
            (!o_out_data.last && o_out_data.status == hdfr_pkg::ST_GOOD))
        else $error("byte transfer malformed");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid && !(i_in_valid && !o_in_stall)) |=> !o_out_valid)
        else $error("result appeared without an input transfer");

endmodule
